[rtl/btff_pkg.sv]
// Package for the boundary tag first-fit allocator.
// Holds pool constants, tag and memory port types, status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btff_pkg;
    localparam int POOL_GRANULES   = 4096;
    localparam int HEADER_GRANULES = 1;
    localparam int ADDR_W          = $clog2(POOL_GRANULES);
    localparam int PTR_W           = ADDR_W + 1;
    localparam int SUM_W           = ADDR_W + 2;
    localparam int SIZE_W          = 12;
    localparam logic [SIZE_W-1:0] SPLIT_RESET = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] POOL_FREE_SIZE = SIZE_W'(POOL_GRANULES - 2 * HEADER_GRANULES);
    localparam logic [PTR_W-1:0]  POOL_END = PTR_W'(POOL_GRANULES);
    localparam logic [PTR_W-1:0]  TWO_H    = PTR_W'(2 * HEADER_GRANULES);
    localparam logic [PTR_W-1:0]  ONE_H    = PTR_W'(HEADER_GRANULES);

    typedef struct packed {
        logic              act;
        logic [SIZE_W-1:0] size;
    } tag_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        tag_t              wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT0, ST_INIT1, ST_IDLE, ST_RD, ST_EV, ST_FB, ST_PF, ST_PB,
        ST_SPL, ST_RDB, ST_MB, ST_RDN, ST_MN, ST_DONE
    } state_t;
endpackage
`default_nettype wire

[rtl/btff_tag_ram.sv]
// Tag memory of the allocator: one tag per granule.
// One write port and one registered read port; uses btff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btff_tag_ram (
    input  wire logic              aclk,
    input  wire btff_pkg::ram_req_t req,
    output btff_pkg::tag_t         rdata
);
    import btff_pkg::*;

    tag_t mem [POOL_GRANULES];
    tag_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/boundary_tag_first_fit_allocator.sv]
// Top level of the boundary tag first-fit allocator: sequencer and result register.
// Depends on btff_pkg and btff_tag_ram.
//
// channel  | dir | payload
// s_*      | in  | tdata: request_size, release_address; tuser: mode
// m_*      | out | tdata: payload_address; tuser: status
// cfg_*    | in  | split_threshold
//
// Allocate: each block on the walk is read (RD) and evaluated (EV); a fit writes its tags
// (PF, PB), a split also the remainder's (SPL, PF, PB). Free: the same walk to the target,
// check (FB), tags (PF, PB), merges (RDB, MB, RDN, MN). DONE then presents the result.
// After reset INIT0 and INIT1 write the whole-pool tags; s_tready stays low meanwhile.
// s_tready is low while an item is in work or a result waits.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // request_size[11:0], release_address[23:12]
    input  wire logic [0:0]  s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // payload_address[11:0], zero[15:12]
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);
    import btff_pkg::*;

    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [SIZE_W-1:0] split_reg;
    logic              mode_reg, mode_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;
    logic [ADDR_W-1:0] rel_reg, rel_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic              fact_reg, fact_next;
    logic [PTR_W-1:0]  pa_reg, pa_next;
    logic [SIZE_W-1:0] ps_reg, ps_next;
    logic              pact_reg, pact_next;
    logic [PTR_W-1:0]  nxt_reg, nxt_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              mvalid_reg, mvalid_next;

    ram_req_t  ram;
    tag_t      rtag;
    logic [SUM_W-1:0] fit_sum;
    logic [PTR_W-1:0] pback;
    logic [SIZE_W-1:0] diff;

    btff_tag_ram u_ram (.aclk(aclk), .req(ram), .rdata(rtag));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT0;
            mvalid_reg <= 1'b0;
            split_reg  <= SPLIT_RESET;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                split_reg <= cfg_wdata;
            end
        end
        ret_reg    <= ret_next;
        mode_reg   <= mode_next;
        rsize_reg  <= rsize_next;
        rel_reg    <= rel_next;
        cur_reg    <= cur_next;
        sz_reg     <= sz_next;
        fact_reg   <= fact_next;
        pa_reg     <= pa_next;
        ps_reg     <= ps_next;
        pact_reg   <= pact_next;
        nxt_reg    <= nxt_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mode_next   = mode_reg;
        rsize_next  = rsize_reg;
        rel_next    = rel_reg;
        cur_next    = cur_reg;
        sz_next     = sz_reg;
        fact_next   = fact_reg;
        pa_next     = pa_reg;
        ps_next     = ps_reg;
        pact_next   = pact_reg;
        nxt_next    = nxt_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        mvalid_next = mvalid_reg && !m_tready;
        ram         = '0;
        s_tready    = (state_reg == ST_IDLE) && !mvalid_reg;
        fit_sum     = SUM_W'(cur_reg) + SUM_W'(rtag.size) + SUM_W'(TWO_H);
        pback       = pa_reg + ONE_H + PTR_W'(ps_reg);
        diff        = rtag.size - rsize_reg;
        unique case (state_reg)
            ST_INIT0: begin
                ram.we    = 1'b1;
                ram.waddr = '0;
                ram.wdata = '{act: 1'b0, size: POOL_FREE_SIZE};
                state_next = ST_INIT1;
            end
            ST_INIT1: begin
                ram.we    = 1'b1;
                ram.waddr = ADDR_W'(POOL_GRANULES - HEADER_GRANULES);
                ram.wdata = '{act: 1'b0, size: POOL_FREE_SIZE};
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    mode_next  = s_tuser[0];
                    rsize_next = s_tdata[11:0];
                    rel_next   = s_tdata[23:12];
                    cur_next   = '0;
                    addr_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                ram.raddr = cur_reg[ADDR_W-1:0];
                if (cur_reg >= POOL_END || (mode_reg && rel_reg == '0)) begin
                    status_next = mode_reg ? STATUS_BAD_FREE : STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_EV;
                end
            end
            ST_EV: begin
                sz_next   = rtag.size;
                fact_next = rtag.act;
                if (fit_sum > SUM_W'(POOL_END)) begin
                    status_next = mode_reg ? STATUS_BAD_FREE : STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end else if (!mode_reg) begin
                    if (!rtag.act && rtag.size >= rsize_reg) begin
                        pa_next     = cur_reg;
                        pact_next   = 1'b1;
                        status_next = STATUS_OK;
                        addr_next   = cur_reg[ADDR_W-1:0] + ADDR_W'(HEADER_GRANULES);
                        state_next  = ST_PF;
                        if (diff > split_reg && PTR_W'(diff) >= TWO_H) begin
                            ps_next  = rsize_reg;
                            ret_next = ST_SPL;
                        end else begin
                            ps_next  = rtag.size;
                            ret_next = ST_DONE;
                        end
                    end else begin
                        cur_next   = fit_sum[PTR_W-1:0];
                        state_next = ST_RD;
                    end
                end else if (cur_reg + ONE_H < PTR_W'(rel_reg)) begin
                    cur_next   = fit_sum[PTR_W-1:0];
                    state_next = ST_RD;
                end else if (cur_reg + ONE_H == PTR_W'(rel_reg)) begin
                    ram.raddr  = ADDR_W'(cur_reg + ONE_H + PTR_W'(rtag.size));
                    state_next = ST_FB;
                end else begin
                    status_next = STATUS_BAD_FREE;
                    state_next  = ST_DONE;
                end
            end
            ST_FB: begin
                if (fact_reg && rtag.act && rtag.size == sz_reg) begin
                    pa_next     = cur_reg;
                    ps_next     = sz_reg;
                    pact_next   = 1'b0;
                    status_next = STATUS_OK;
                    ret_next    = ST_RDB;
                    state_next  = ST_PF;
                end else begin
                    status_next = STATUS_BAD_FREE;
                    state_next  = ST_DONE;
                end
            end
            ST_PF: begin
                ram.we     = pa_reg < POOL_END;
                ram.waddr  = pa_reg[ADDR_W-1:0];
                ram.wdata  = '{act: pact_reg, size: ps_reg};
                state_next = ST_PB;
            end
            ST_PB: begin
                ram.we     = pback < POOL_END;
                ram.waddr  = pback[ADDR_W-1:0];
                ram.wdata  = '{act: pact_reg, size: ps_reg};
                state_next = ret_reg;
            end
            ST_SPL: begin
                pa_next    = cur_reg + PTR_W'(rsize_reg) + TWO_H;
                ps_next    = sz_reg - rsize_reg - SIZE_W'(TWO_H);
                pact_next  = 1'b0;
                ret_next   = ST_DONE;
                state_next = ST_PF;
            end
            ST_RDB: begin
                ram.raddr  = ADDR_W'(pa_reg - ONE_H);
                state_next = (pa_reg >= ONE_H) ? ST_MB : ST_RDN;
            end
            ST_MB: begin
                state_next = ST_RDN;
                if (!rtag.act && PTR_W'(rtag.size) + TWO_H <= pa_reg) begin
                    pa_next    = pa_reg - PTR_W'(rtag.size) - TWO_H;
                    ps_next    = rtag.size + ps_reg + SIZE_W'(TWO_H);
                    ret_next   = ST_RDN;
                    state_next = ST_PF;
                end
            end
            ST_RDN: begin
                nxt_next   = pa_reg + PTR_W'(ps_reg) + TWO_H;
                ram.raddr  = ADDR_W'(pa_reg + PTR_W'(ps_reg) + TWO_H);
                state_next = (pa_reg + PTR_W'(ps_reg) + TWO_H < POOL_END) ? ST_MN : ST_DONE;
            end
            ST_MN: begin
                state_next = ST_DONE;
                if (!rtag.act && SUM_W'(nxt_reg) + SUM_W'(rtag.size) + SUM_W'(TWO_H)
                        <= SUM_W'(POOL_END)) begin
                    ps_next    = ps_reg + rtag.size + SIZE_W'(TWO_H);
                    ret_next   = ST_DONE;
                    state_next = ST_PF;
                end
            end
            ST_DONE: begin
                if (status_reg != STATUS_OK || mode_reg) begin
                    addr_next = '0;
                end
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0, addr_reg};
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
        else $error("nonzero address on failed item");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");
    a_no_result_while_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT0 || state_reg == ST_INIT1) |-> !mvalid_reg)
        else $error("result during init");
    a_done_raises_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> mvalid_reg)
        else $error("result not presented");
`endif
endmodule
`default_nettype wire

[tb/boundary_tag_first_fit_allocator_test.sv]
// Self-checking testbench for boundary_tag_first_fit_allocator.
// Drives allocate and free items through the stream ports and checks each result
// against an in-bench tag-store model. Depends on btff_pkg and the allocator RTL.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_test;
    import btff_pkg::*;

    localparam int POOL = POOL_GRANULES;
    localparam int HDR  = HEADER_GRANULES;

    typedef struct {
        status_t     status;
        logic [11:0] addr;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;

    boundary_tag_first_fit_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // allocator model state
    bit          tag_act [POOL];
    int          tag_size[POOL];
    int          split_thresh;
    grant_t      grant_q[$];
    int          live_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    function automatic void write_tags(int a, int s, bit act);
        int back;
        back = a + HDR + s;
        if (a < POOL) begin
            tag_act[a] = act;
            tag_size[a] = s;
        end
        if (back < POOL) begin
            tag_act[back] = act;
            tag_size[back] = s;
        end
    endfunction

    function automatic bit block_in_pool(int a);
        if (a >= POOL) return 1'b0;
        return a + tag_size[a] + 2 * HDR <= POOL;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++) begin
            tag_act[i] = 1'b0;
            tag_size[i] = 0;
        end
        write_tags(0, POOL - 2 * HDR, 1'b0);
        split_thresh = 16;
    endfunction

    function automatic void coalesce(int a);
        int s;
        int bt;
        int nxt;
        s = tag_size[a];
        write_tags(a, s, 1'b0);
        if (a >= HDR) begin
            bt = a - HDR;
            if (!tag_act[bt] && tag_size[bt] + 2 * HDR <= a) begin
                s = tag_size[bt] + s + 2 * HDR;
                a = a - tag_size[bt] - 2 * HDR;
                write_tags(a, s, 1'b0);
            end
        end
        nxt = a + s + 2 * HDR;
        if (nxt < POOL && !tag_act[nxt] && block_in_pool(nxt)) begin
            s = s + tag_size[nxt] + 2 * HDR;
            write_tags(a, s, 1'b0);
        end
    endfunction

    function automatic grant_t predict_grant(bit mode, int req, int rel);
        grant_t g;
        int cur;
        int diff;
        int target;
        int back;
        req = req & 'hFFF;
        rel = rel & 'hFFF;
        cur = 0;
        g.addr = '0;
        if (mode == 1'b0) begin
            g.status = STATUS_NO_SPACE;
            while (block_in_pool(cur)) begin
                if (!tag_act[cur] && tag_size[cur] >= req) begin
                    diff = tag_size[cur] - req;
                    if (diff > split_thresh && diff >= 2 * HDR) begin
                        write_tags(cur, req, 1'b1);
                        write_tags(cur + req + 2 * HDR, diff - 2 * HDR, 1'b0);
                    end else begin
                        write_tags(cur, tag_size[cur], 1'b1);
                    end
                    g.status = STATUS_OK;
                    g.addr = 12'(cur + HDR);
                    live_q.push_back(cur + HDR);
                    break;
                end
                cur = cur + tag_size[cur] + 2 * HDR;
            end
        end else begin
            g.status = STATUS_BAD_FREE;
            if (rel >= HDR) begin
                target = rel - HDR;
                while (block_in_pool(cur) && cur < target)
                    cur = cur + tag_size[cur] + 2 * HDR;
                if (cur == target && block_in_pool(cur)) begin
                    back = cur + HDR + tag_size[cur];
                    if (tag_act[cur] && tag_act[back] && tag_size[back] == tag_size[cur]) begin
                        coalesce(cur);
                        g.status = STATUS_OK;
                        foreach (live_q[i])
                            if (live_q[i] == rel) begin
                                live_q.delete(i);
                                break;
                            end
                    end
                end
            end
        end
        return g;
    endfunction

    task automatic send_item(bit mode, int req, int rel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {12'(rel), 12'(req)};
        do @(posedge aclk); while (!s_tready);
        grant_q.push_back(predict_grant(mode, req, rel));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_split(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= 12'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        split_thresh = v;
    endtask

    // receiver: stall, long hold-off, and result check
    always @(posedge aclk) begin
        grant_t g;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d addr %0d", m_tuser, m_tdata);
            end else begin
                g = grant_q.pop_front();
                if (m_tuser != g.status || m_tdata != {4'd0, g.addr}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                                 g.status, g.addr, m_tuser, m_tdata);
                end
            end
        end
    end

    task automatic random_item();
        int pick;
        int req;
        int rel;
        pick = $urandom_range(99);
        if (live_q.size() == 0 || (live_q.size() < 48 && pick < 55)) begin
            pick = $urandom_range(99);
            if (pick < 85) req = $urandom_range(0, 40);
            else if (pick < 95) req = $urandom_range(0, 400);
            else req = $urandom_range(0, 4094);
            send_item(1'b0, req, $urandom_range(0, 4095));
        end else begin
            pick = $urandom_range(99);
            if (pick < 85) rel = live_q[$urandom_range(0, live_q.size() - 1)];
            else if (pick < 92) rel = $urandom_range(0, 4095);
            else rel = live_q[$urandom_range(0, live_q.size() - 1)] + $urandom_range(1, 3);
            send_item(1'b1, $urandom_range(0, 4094), rel);
        end
    endtask

    task automatic test_directed();
        int a;
        send_item(1'b0, 0, 4095);
        send_item(1'b0, 4094, 0);
        send_item(1'b1, 0, 0);
        send_item(1'b1, 0, 4095);
        send_item(1'b0, 10, 0);
        a = live_q[live_q.size() - 1];
        send_item(1'b1, 4094, a + 1);
        send_item(1'b1, 0, a);
        send_item(1'b1, 0, a);
        send_item(1'b0, 4070, 0);
        send_item(1'b0, 0, 0);
        while (live_q.size() != 0) send_item(1'b1, 0, live_q[0]);
        set_split(4095);
        send_item(1'b0, 5, 0);
        send_item(1'b0, 1, 0);
        send_item(1'b1, 0, live_q[0]);
        set_split(0);
        send_item(1'b0, 4092, 0);
        send_item(1'b0, 0, 0);
        send_item(1'b0, 0, 0);
        while (live_q.size() != 0) send_item(1'b1, 0, live_q[live_q.size() - 1]);
        send_item(1'b0, 4094, 0);
        send_item(1'b1, 0, live_q[0]);
    endtask

    task automatic test_random_phase(int n, int idle, int stall, int split);
        set_split(split);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) random_item();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_split(16);
        hold_cycles = 400;
        repeat (30) random_item();
        drain();
        repeat (20) random_item();
    endtask

    initial begin
        pool_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(400, 0, 0, 16);
        test_random_phase(250, 80, 0, 0);
        test_random_phase(150, 0, 80, 4095);
        test_random_phase(300, 22, 22, $urandom_range(1, 200));
        test_backpressure();
        test_random_phase(400, 0, 0, 3);
        drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("boundary_tag_first_fit_allocator regression: pass");
        end else begin
            $display("boundary_tag_first_fit_allocator regression: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("boundary_tag_first_fit_allocator regression: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/btff_pkg.sv
rtl/btff_tag_ram.sv
rtl/boundary_tag_first_fit_allocator.sv
tb/boundary_tag_first_fit_allocator_test.sv
